// ===== hdl/sfb_pkg.sv =====
`timescale 1ns / 1ps

package sfb_pkg;

    // Frame constants
    localparam logic [7:0] FRAME_START_BYTE = 8'hFD;
    localparam logic [7:0] LEN_HIGH_BYTE    = 8'h00;
    localparam logic [7:0] LEN_OFFSET       = 8'd3;
    localparam logic [7:0] MAX_TEXT_LEN     = 8'd252;

    // Position of a result within one transaction's burst (up to six results)
    localparam int unsigned POS_W = 3;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_START = 3'd0;
    localparam logic [POS_W-1:0] POS_LENHI = 3'd1;
    localparam logic [POS_W-1:0] POS_LENLO = 3'd2;
    localparam logic [POS_W-1:0] POS_CMD   = 3'd3;
    localparam logic [POS_W-1:0] POS_ARG   = 3'd4;
    localparam logic [POS_W-1:0] POS_HCHK  = 3'd5;
    localparam logic [POS_W-1:0] POS_TEXT  = 3'd0;
    localparam logic [POS_W-1:0] POS_TCHK  = 3'd1;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_TEXT,
        KIND_STRAY
    } burst_kind_t;

    typedef struct packed {
        logic       action;
        logic [7:0] command;
        logic [7:0] argument;
        logic [7:0] text_length;
        logic [7:0] text_byte;
    } sfb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       stray_error;
    } sfb_out_t;

    // Everything needed to regenerate any result of one accepted transaction
    typedef struct packed {
        burst_kind_t      kind;
        logic [7:0]       len_byte;
        logic [7:0]       command;
        logic [7:0]       argument;
        logic [7:0]       text_byte;
        logic [7:0]       check;
        logic [POS_W-1:0] last_pos;
    } burst_rec_t;

endpackage

// ===== hdl/speech_frame_builder.sv =====
`timescale 1ns / 1ps

// Channel   Ports                      Handshake      Payload
// input     s_valid s_ready s_data     valid/ready    sfb_in_t  (one start or text item)
// output    m_valid m_ready m_data     valid/ready    sfb_out_t (one serial byte)
//
// A text transaction yields one result, or two when it closes the frame; a start
// yields five header bytes, plus the check byte when the text length is zero.
// Results leave at one per cycle unless m_ready stalls them, so text that does not close
// the frame sustains one transaction per cycle; the burst register replays each burst.
// Reset (aresetn low, synchronous) closes any frame and empties both stages.
// A stalled output holds its byte; one more transaction is still taken into the
// burst register behind it, after which s_ready drops until the burst drains.

module speech_frame_builder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sfb_pkg::sfb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sfb_pkg::sfb_out_t m_data
);
    import sfb_pkg::*;

    // Frame state
    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] check_accum_reg, check_accum_next;

    // Burst stage: one accepted transaction, replayed one result per cycle while the output register frees
    burst_rec_t       burst_reg, burst_next;
    logic             burst_valid_reg, burst_valid_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // Output register
    logic     m_valid_reg, m_valid_next;
    sfb_out_t m_data_reg, m_data_next;

    sfb_out_t   gen_result;
    logic       accept;
    logic       out_load;
    logic       burst_move;
    logic       burst_done;
    logic [7:0] len_clamped;
    logic [7:0] len_byte;
    logic [7:0] hdr_check;
    logic [7:0] text_check;
    logic [7:0] left_dec;

    sfb_result_gen u_result_gen (
        .rec    (burst_reg),
        .pos    (pos_reg),
        .result (gen_result)
    );

    // Output register frees when empty or being taken this cycle
    assign out_load   = !m_valid_reg || m_ready;
    assign burst_move = burst_valid_reg && out_load;
    assign burst_done = burst_move && (pos_reg == burst_reg.last_pos);

    // Take a new transaction once the burst stage empties or hands off its last result
    assign s_ready = !burst_valid_reg || burst_done;
    assign accept  = s_valid && s_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Header fields and checks
    assign len_clamped = (s_data.text_length > MAX_TEXT_LEN) ? MAX_TEXT_LEN : s_data.text_length;
    assign len_byte    = len_clamped + LEN_OFFSET;
    assign hdr_check   = FRAME_START_BYTE ^ LEN_HIGH_BYTE ^ len_byte
                       ^ s_data.command ^ s_data.argument;
    assign text_check  = check_accum_reg ^ s_data.text_byte;
    assign left_dec    = (bytes_left_reg != 8'd0) ? (bytes_left_reg - 8'd1) : 8'd0;

    always_comb begin
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        check_accum_next = check_accum_reg;
        burst_next       = burst_reg;
        burst_valid_next = burst_valid_reg;
        pos_next         = pos_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        // Advance the burst into the output register
        if (burst_move) begin
            m_data_next  = gen_result;
            m_valid_next = 1'b1;
            pos_next     = pos_reg + 1'b1;
            if (burst_done) begin
                burst_valid_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            burst_valid_next   = 1'b1;
            pos_next           = '0;
            burst_next.len_byte  = len_byte;
            burst_next.command   = s_data.command;
            burst_next.argument  = s_data.argument;
            burst_next.text_byte = s_data.text_byte;
            if (!s_data.action) begin
                // Start: open a fresh frame, discarding any open one
                burst_next.kind  = KIND_HEADER;
                burst_next.check = hdr_check;
                if (len_clamped == 8'd0) begin
                    burst_next.last_pos = POS_HCHK;
                    frame_open_next     = 1'b0;
                    bytes_left_next     = 8'd0;
                    check_accum_next    = 8'd0;
                end else begin
                    burst_next.last_pos = POS_ARG;
                    frame_open_next     = 1'b1;
                    bytes_left_next     = len_clamped;
                    check_accum_next    = hdr_check;
                end
            end else if (!frame_open_reg) begin
                // Stray text byte: drop it, flag it, leave the state alone
                burst_next.kind     = KIND_STRAY;
                burst_next.check    = check_accum_reg;
                burst_next.last_pos = POS_START;
            end else begin
                burst_next.kind  = KIND_TEXT;
                burst_next.check = text_check;
                bytes_left_next  = left_dec;
                if (left_dec == 8'd0) begin
                    // Last declared byte: close the frame with the check byte
                    burst_next.last_pos = POS_TCHK;
                    frame_open_next     = 1'b0;
                    check_accum_next    = 8'd0;
                end else begin
                    burst_next.last_pos = POS_TEXT;
                    check_accum_next    = text_check;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 8'd0;
            check_accum_reg <= 8'd0;
            burst_valid_reg <= 1'b0;
            pos_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            check_accum_reg <= check_accum_next;
            burst_valid_reg <= burst_valid_next;
            pos_reg         <= pos_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge aclk) begin
        burst_reg  <= burst_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hdl/sfb_result_gen.sv =====
`timescale 1ns / 1ps

module sfb_result_gen (
    input  sfb_pkg::burst_rec_t       rec,
    input  logic [sfb_pkg::POS_W-1:0] pos,
    output sfb_pkg::sfb_out_t         result
);
    import sfb_pkg::*;

    always_comb begin
        result          = '0;
        result.run_last = (pos == rec.last_pos);
        case (rec.kind)
            KIND_HEADER: begin
                case (pos)
                    POS_START: result.out_byte = FRAME_START_BYTE;
                    POS_LENHI: result.out_byte = LEN_HIGH_BYTE;
                    POS_LENLO: result.out_byte = rec.len_byte;
                    POS_CMD:   result.out_byte = rec.command;
                    POS_ARG:   result.out_byte = rec.argument;
                    default: begin
                        result.out_byte  = rec.check;
                        result.frame_end = 1'b1;
                    end
                endcase
            end
            KIND_TEXT: begin
                if (pos == POS_TEXT) begin
                    result.out_byte = rec.text_byte;
                end else begin
                    result.out_byte  = rec.check;
                    result.frame_end = 1'b1;
                end
            end
            KIND_STRAY: begin
                result.stray_error = 1'b1;
            end
            default: begin
                result.out_byte = '0;
            end
        endcase
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sfb_pkg::*;

    // Input transaction kinds (the action bit)
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TEXT  = 1'b1;

    // Length of the long output stall, and the quiet stretch that counts as a hang
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 20;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sfb_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sfb_out_t m_data;

    // Upper bound on idle cycles per transaction for both sides (0 = no idling)
    int unsigned idle_max     = 16;
    // Set by the stimulus to make the result side stall once for that many cycles
    int unsigned hold_request = 0;

    // Frame-builder state mirrored by the predictor
    logic       open_frame   = 1'b0;
    logic [7:0] text_pending = '0;
    logic [7:0] frame_xor    = '0;

    // Bytes the block still owes us, oldest first
    sfb_out_t    pending_bytes[$];

    int unsigned failures       = 0;
    int unsigned items_sent     = 0;
    int unsigned starts_sent    = 0;
    int unsigned strays_sent    = 0;
    int unsigned bytes_checked  = 0;

    speech_frame_builder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic sfb_out_t serial_byte(input logic [7:0] value, input logic last,
                                             input logic closing, input logic stray);
        sfb_out_t r;
        r.out_byte    = value;
        r.run_last    = last;
        r.frame_end   = closing;
        r.stray_error = stray;
        return r;
    endfunction

    // Queue the bytes one accepted transaction must produce and advance the mirror state.
    task automatic predict_frame_bytes(input sfb_in_t t);
        logic [7:0]      len;
        logic [0:4][7:0] header;
        begin
            if (t.action == ACT_START) begin
                starts_sent++;
                // Clamp over-long text; the header and the count both use the clamped length
                len = (t.text_length > MAX_TEXT_LEN) ? MAX_TEXT_LEN : t.text_length;
                header = {FRAME_START_BYTE, LEN_HIGH_BYTE, 8'(len + LEN_OFFSET),
                          t.command, t.argument};
                // A start always begins a fresh checksum, dropping any open frame
                frame_xor = '0;
                for (int i = 0; i < 5; i++) begin
                    frame_xor = frame_xor ^ header[i];
                    pending_bytes.push_back(serial_byte(header[i],
                                                        (i == 4) && (len != 0), 1'b0, 1'b0));
                end
                if (len == 0) begin
                    // Empty text: close at once with the check byte
                    pending_bytes.push_back(serial_byte(frame_xor, 1'b1, 1'b1, 1'b0));
                    open_frame   = 1'b0;
                    text_pending = '0;
                    frame_xor    = '0;
                end else begin
                    open_frame   = 1'b1;
                    text_pending = len;
                end
            end else if (!open_frame) begin
                // Stray text byte: flag it, drop the byte, leave the state alone
                strays_sent++;
                pending_bytes.push_back(serial_byte(8'h00, 1'b1, 1'b0, 1'b1));
            end else begin
                frame_xor = frame_xor ^ t.text_byte;
                if (text_pending != 0)
                    text_pending = text_pending - 8'd1;
                if (text_pending == 0) begin
                    pending_bytes.push_back(serial_byte(t.text_byte, 1'b0, 1'b0, 1'b0));
                    pending_bytes.push_back(serial_byte(frame_xor, 1'b1, 1'b1, 1'b0));
                    open_frame = 1'b0;
                    frame_xor  = '0;
                end else begin
                    pending_bytes.push_back(serial_byte(t.text_byte, 1'b1, 1'b0, 1'b0));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Fields a transaction does not use get random junk so the block must ignore them.
    function automatic sfb_in_t start_item(input logic [7:0] cmd, input logic [7:0] arg,
                                           input logic [7:0] len);
        sfb_in_t t;
        t.action      = ACT_START;
        t.command     = cmd;
        t.argument    = arg;
        t.text_length = len;
        t.text_byte   = 8'($urandom_range(0, 255));
        return t;
    endfunction

    function automatic sfb_in_t text_item(input logic [7:0] value);
        sfb_in_t t;
        t.action      = ACT_TEXT;
        t.command     = 8'($urandom_range(0, 255));
        t.argument    = 8'($urandom_range(0, 255));
        t.text_length = 8'($urandom_range(0, 255));
        t.text_byte   = value;
        return t;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted.
    // Returns right after the accepting edge; valid is still high at that point.
    task automatic send_item(input sfb_in_t t);
        int unsigned gap;
        begin
            gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
            @(negedge aclk);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= t;
            do @(posedge aclk); while (!s_ready);
            items_sent++;
            predict_frame_bytes(t);
        end
    endtask

    // Drop valid and wait until every owed byte has come back.
    task automatic hold_until_drained();
        begin
            @(negedge aclk);
            s_valid <= 1'b0;
            while (pending_bytes.size() != 0) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and every special case: stray bytes, empty text, clamping, restarts.
    task automatic test_directed();
        begin
            idle_max = 16;
            send_item(text_item(8'hFF));                  // stray right after reset
            send_item(start_item(8'hFF, 8'h00, 8'd0));    // empty text, check byte follows
            send_item(start_item(8'h00, 8'hFF, 8'd1));
            send_item(text_item(8'h00));                  // single byte closes the frame
            send_item(start_item(8'hA5, 8'h5A, 8'd3));
            send_item(text_item(8'h55));
            send_item(start_item(8'h5A, 8'hA5, 8'd255));  // restart with a clamped length
            send_item(text_item(8'hAA));
            send_item(start_item(8'h01, 8'h80, 8'd253));  // restart, just over the limit
            send_item(start_item(8'h81, 8'h7E, 8'd2));
            send_item(text_item(8'h12));
            send_item(text_item(8'h34));
            send_item(text_item(8'h80));                  // stray after a closed frame
            send_item(start_item(8'h33, 8'hCC, 8'd252));  // exactly the limit
            send_item(text_item(8'h0F));
            send_item(start_item(8'h10, 8'h01, 8'd128));
            send_item(start_item(8'h02, 8'h03, 8'd0));    // empty restart closes everything
            send_item(text_item(8'h7F));                  // so this one is stray
            hold_until_drained();
        end
    endtask

    // Stall the result side for a long stretch while starts keep coming,
    // so the block fills and drops s_ready.
    task automatic test_output_stall();
        begin
            idle_max     = 0;
            hold_request = HOLD_CYCLES;
            for (int i = 0; i < 8; i++)
                send_item(start_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'd0));
            send_item(start_item(8'h44, 8'h01, 8'd4));
            for (int i = 0; i < 4; i++)
                send_item(text_item(8'($urandom_range(0, 255))));
            hold_until_drained();
        end
    endtask

    // One frame of the largest length, streamed back to back at first, to walk the count down fully.
    task automatic test_longest_frame();
        begin
            idle_max = 0;
            send_item(start_item(8'h01, 8'h00, 8'd255));
            for (int i = 0; i < MAX_TEXT_LEN; i++) begin
                // Let idling creep in over the second half of the text
                if (i == MAX_TEXT_LEN / 2)
                    idle_max = 4;
                send_item(text_item(8'($urandom_range(0, 255))));
            end
            hold_until_drained();
        end
    endtask

    // Mostly complete frames with random content; some abandoned frames, clamped
    // lengths and stray bytes mixed in. Idling switches on and off in stretches.
    task automatic test_random_frames(input int unsigned count);
        int unsigned first;
        int unsigned pick;
        int unsigned texts;
        logic [7:0]  len;
        begin
            first    = items_sent;
            idle_max = 16;
            while (items_sent - first < count) begin
                if ($urandom_range(0, 5) == 0)
                    idle_max = ($urandom_range(0, 1) == 0) ? 0 : 16;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = 8'd0;
                else if (pick < 75)
                    len = 8'($urandom_range(1, 6));
                else if (pick < 93)
                    len = 8'($urandom_range(7, 24));
                else
                    len = 8'($urandom_range(253, 255));
                send_item(start_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     len));
                // Clamped frames are cut short; a few others are abandoned for a restart
                if (len > MAX_TEXT_LEN)
                    texts = $urandom_range(0, 8);
                else if (len != 0 && $urandom_range(0, 9) == 0)
                    texts = $urandom_range(0, len - 1);
                else
                    texts = len;
                for (int k = 0; k < texts; k++)
                    send_item(text_item(8'($urandom_range(0, 255))));
                // Noise: an extra text byte, stray unless the frame was left open
                if ($urandom_range(0, 7) == 0)
                    send_item(text_item(8'($urandom_range(0, 255))));
            end
            hold_until_drained();
        end
    endtask

    // Pause the sender with the block fully drained, then pick up mid-pattern.
    task automatic test_pause_after_drain();
        begin
            idle_max = 16;
            send_item(start_item(8'h22, 8'h03, 8'd3));
            send_item(text_item(8'h61));
            hold_until_drained();
            send_item(text_item(8'h62));
            send_item(text_item(8'h63));
            hold_until_drained();
            send_item(text_item(8'h64));
            hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold on request, field-by-field check
    // ------------------------------------------------------------------

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        begin
            if (want != got) begin
                $error("%s mismatch: expected %0h, got %0h", field, want, got);
                failures++;
            end
        end
    endtask

    initial begin : result_checker
        int unsigned stall;
        sfb_out_t    want;
        wait (aresetn === 1'b1);
        forever begin
            stall = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
            if (hold_request != 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_bytes.size() == 0) begin
                $error("result with nothing expected: out_byte %0h", m_data.out_byte);
                failures++;
            end else begin
                want = pending_bytes.pop_front();
                compare_field("out_byte", want.out_byte, m_data.out_byte);
                compare_field("run_last", want.run_last, m_data.run_last);
                compare_field("frame_end", want.frame_end, m_data.frame_end);
                compare_field("stray_error", want.stray_error, m_data.stray_error);
                bytes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves a transaction for too long
    // ------------------------------------------------------------------

    initial begin : hang_watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d bytes still owed",
                 WATCHDOG_LIMIT, pending_bytes.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_output_stall();
        test_longest_frame();
        test_random_frames(30);
        test_pause_after_drain();

        // Give any stray extra output a chance to show up before judging
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d transactions (%0d frame starts, %0d stray text bytes),",
                 items_sent, starts_sent, strays_sent);
        $display("checked %0d bytes over empty, clamped and full-length frames, restarts",
                 bytes_checked);
        $display("and a %0d-cycle output stall.", HOLD_CYCLES);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
